FILE: rtl/wildcard_byte_signature_scan_core_defines.svh
// Assertion macros for the wildcard byte signature scan core.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_CORE_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_CORE_DEFINES_SVH

// same-cycle implication
`define WBSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WBSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wbss_pkg.sv
// Shared types, constants and helper functions of the signature scan core.
// No dependencies; imported by every module of the block.
`default_nettype none

package wbss_pkg;

  localparam int DEF_MAX_TEMPLATE_BYTES = 16;
  localparam int DEF_MAX_CAPTURES       = 8;
  localparam int DEF_OFFSET_BITS        = 32;

  localparam int POS_LIMIT   = 16;
  localparam int WORD_BYTES  = 4;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 64;
  localparam int CNT_W       = 4;
  localparam int IDX_OUT_W   = 3;

  localparam logic [CFG_AW-1:0] REG_PAT_LO   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PAT_HI   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CMP_MASK = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CAP_MASK = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TLEN     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_STEP     = 3'd5;

  localparam logic [4:0] STEP_RESET = 5'd4;
  localparam logic [4:0] STEP_MAX   = 5'd16;

  typedef struct packed {
    logic       cmp_en;
    logic [7:0] lit;
  } cell_cfg_t;

  typedef struct packed {
    logic             found;
    logic [31:0]      match_offset;
    logic [CNT_W-1:0] arg_count;
  } rep_hdr_t;

  // remainder of a 4-bit value by a step of 1..16
  function automatic logic [3:0] mod_small(input logic [3:0] x, input logic [4:0] s);
    logic [8:0] lo;
    logic [8:0] xe;
    logic [3:0] r;
    r  = '0;
    xe = {5'b0, x};
    for (int q = 0; q < POS_LIMIT; q++) begin
      lo = 9'(q) * {4'b0, s};
      if (xe >= lo && xe < lo + {4'b0, s}) begin
        r = 4'(xe - lo);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wbss_cell.sv
// One byte cell of the scan window: holds a byte, passes it down the chain.
// Compares the byte it takes in against its aligned literal. Uses wbss_pkg.
`default_nettype none

module wbss_cell (
  input  wire logic                clk_i,
  input  wire logic                advance_i,
  input  wire logic [7:0]          byte_in_i,
  input  wire wbss_pkg::cell_cfg_t cfg_i,
  output logic [7:0]               byte_q_o,
  output logic                     miss_o
);
  import wbss_pkg::*;

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      byte_q <= byte_in_i;
    end
  end

  assign byte_q_o = byte_q;
  assign miss_o   = cfg_i.cmp_en && (byte_in_i != cfg_i.lit);

endmodule

`default_nettype wire

FILE: rtl/wbss_report.sv
// Report buffer: holds one match or not-found report and sends its items one a
// cycle while the receiver is ready. Uses wbss_pkg for the report header type.
`default_nettype none

module wbss_report #(
  parameter int RUN_SLOTS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire wbss_pkg::rep_hdr_t             hdr_i,
  input  wire logic [RUN_SLOTS-1:0][31:0]     vals_i,
  output logic                                busy_o,
  output logic                                last_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                found_o,
  output logic [31:0]                         match_offset_o,
  output logic [wbss_pkg::CNT_W-1:0]          arg_count_o,
  output logic [wbss_pkg::IDX_OUT_W-1:0]      arg_index_o,
  output logic [31:0]                         arg_value_o,
  output logic                                last_result_o
);
  import wbss_pkg::*;

  localparam int IDX_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;

  logic                       valid_q, valid_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  rep_hdr_t                   hdr_q;
  logic [RUN_SLOTS-1:0][31:0] vals_q;
  logic [CNT_W-1:0]           n_items;
  logic                       last;
  logic                       fire;

  assign n_items = (hdr_q.arg_count == '0) ? CNT_W'(1) : hdr_q.arg_count;
  assign last    = (CNT_W'(idx_q) + CNT_W'(1)) == n_items;
  assign fire    = valid_q && out_ready_i;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (fire) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hdr_q  <= hdr_i;
      vals_q <= vals_i;
    end
  end

  assign busy_o         = valid_q;
  assign last_o         = last;
  assign out_valid_o    = valid_q;
  assign found_o        = hdr_q.found;
  assign match_offset_o = hdr_q.match_offset;
  assign arg_count_o    = hdr_q.arg_count;
  assign arg_index_o    = IDX_OUT_W'(idx_q);
  assign arg_value_o    = vals_q[idx_q];
  assign last_result_o  = last;

endmodule

`default_nettype wire

FILE: rtl/wildcard_byte_signature_scan_core.sv
// Wildcard byte signature scan: a chain of byte cells matched against a template.
// Depends on wbss_pkg, wbss_cell, wbss_report and the assertion macro header.
//
// Usage:
//  Bytes of a region enter on the valid/ready input, one per cycle unless stalled
//  last_byte_i marking the final byte. The configuration port writes template
//  registers at any cycle the block is idle; writes take effect at once.
//  Every accepted byte is judged in its accept cycle against the template,
//  read from the cell chain with that byte shifted in. A match or a not-found
//  report lands in the report buffer at that edge and its first item shows on
//  the output channel in the following cycle; a report of n capture runs is sent
//  as n items (one if n is zero), one item a cycle while the receiver is ready.
//  Throughput is one byte per cycle unless stalled. While a report is sent the
//  input stalls only if the next byte could raise a new report, i.e. until the
//  last item of that report is taken; bytes after a match keep flowing.
//  When the receiver stalls, the current item holds and, once a new report
//  would be needed, the input stalls too.
//  Reset clears the region state (offset, phase, match flag), the report
//  buffer and the template registers; align step resets to four.
`default_nettype none

module wildcard_byte_signature_scan_core #(
  parameter int MAX_TEMPLATE_BYTES = wbss_pkg::DEF_MAX_TEMPLATE_BYTES,
  parameter int MAX_CAPTURES       = wbss_pkg::DEF_MAX_CAPTURES,
  parameter int OFFSET_BITS        = wbss_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [wbss_pkg::CFG_AW-1:0]       cfg_addr_i,
  input  wire logic [wbss_pkg::CFG_DW-1:0]       cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              last_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   found_o,
  output logic [31:0]                            match_offset_o,
  output logic [wbss_pkg::CNT_W-1:0]             arg_count_o,
  output logic [wbss_pkg::IDX_OUT_W-1:0]         arg_index_o,
  output logic [31:0]                            arg_value_o,
  output logic                                   last_result_o
);
  import wbss_pkg::*;

`include "wildcard_byte_signature_scan_core_defines.svh"

  localparam int MAXB      = MAX_TEMPLATE_BYTES;
  localparam int NPOS      = (MAXB < POS_LIMIT) ? MAXB : POS_LIMIT;
  localparam int RUN_MAX   = (NPOS + 1) / 2;
  localparam int RUN_SLOTS = (MAX_CAPTURES < RUN_MAX) ? MAX_CAPTURES : RUN_MAX;
  localparam int RANK_W    = $clog2(MAXB + 1);

  // configuration registers
  logic [63:0] pat_lo_q, pat_hi_q;
  logic [15:0] cmp_mask_q, cap_mask_q;
  logic [4:0]  tlen_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      cmp_mask_q <= '0;
      cap_mask_q <= '0;
      tlen_q     <= '0;
      step_q     <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PAT_LO:   pat_lo_q   <= cfg_wdata_i;
        REG_PAT_HI:   pat_hi_q   <= cfg_wdata_i;
        REG_CMP_MASK: cmp_mask_q <= cfg_wdata_i[15:0];
        REG_CAP_MASK: cap_mask_q <= cfg_wdata_i[15:0];
        REG_TLEN:     tlen_q     <= cfg_wdata_i[4:0];
        REG_STEP:     step_q     <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // effective template length and step
  logic [4:0]   len_eff, step_eff;
  logic [3:0]   len_m1;
  logic [127:0] pat_all;

  assign len_eff  = (tlen_q > 5'(NPOS)) ? 5'(NPOS) : tlen_q;
  assign step_eff = (step_q == '0) ? 5'd1 : ((step_q > STEP_MAX) ? STEP_MAX : step_q);
  assign len_m1   = 4'(len_eff - 5'd1);
  assign pat_all  = {pat_hi_q, pat_lo_q};

  // region state
  logic [OFFSET_BITS-1:0] byte_cnt_q, byte_cnt_d;
  logic [3:0]             phase_q, phase_d;
  logic                   match_done_q, match_done_d;
  logic                   in_fire;

  // align template positions to cells: cell MAXB-len holds position zero
  cell_cfg_t  cell_cfg [MAXB];
  logic       cap_a    [MAXB];

  always_comb begin
    int kk;
    logic [3:0] k;
    for (int j = 0; j < MAXB; j++) begin
      kk = j + int'(len_eff) - MAXB;
      k  = 4'(kk);
      cell_cfg[j].lit    = pat_all[8*k +: 8];
      cap_a[j]           = (kk >= 0) && cap_mask_q[k];
      cell_cfg[j].cmp_en = (kk >= 0) && cmp_mask_q[k] && !cap_mask_q[k];
    end
  end

  // cell chain, newest byte at the top
  logic [7:0] cell_q  [MAXB];
  logic [7:0] cell_in [MAXB];
  logic [MAXB-1:0] miss;

  for (genvar g = 0; g < MAXB; g++) begin : g_cell
    if (g == MAXB - 1) begin : g_top
      assign cell_in[g] = data_byte_i;
    end else begin : g_mid
      assign cell_in[g] = cell_q[g+1];
    end
    wbss_cell u_cell (
      .clk_i     (clk_i),
      .advance_i (in_fire),
      .byte_in_i (cell_in[g]),
      .cfg_i     (cell_cfg[g]),
      .byte_q_o  (cell_q[g]),
      .miss_o    (miss[g])
    );
  end

  // capture runs, taken from the window as it stands after the shift
  logic [MAXB-1:0]              run_start;
  logic [MAXB+2:0]              cap_pad;
  logic [7:0]                   nb_pad   [MAXB+3];
  logic [31:0]                  run_word [MAXB];
  logic [RANK_W-1:0]            rank     [MAXB];
  logic [RUN_SLOTS-1:0][31:0]   vals;
  logic [RANK_W-1:0]            runs_raw;
  logic [CNT_W-1:0]             runs_cnt;

  always_comb begin
    logic alive;
    cap_pad = '0;
    for (int j = 0; j < MAXB + 3; j++) begin
      nb_pad[j] = '0;
    end
    for (int j = 0; j < MAXB; j++) begin
      cap_pad[j] = cap_a[j];
      nb_pad[j]  = cell_in[j];
    end
    for (int j = 0; j < MAXB; j++) begin
      run_start[j] = cap_a[j] && ((j == 0) || !cap_pad[(j == 0) ? 0 : j-1]);
    end
    for (int j = 0; j < MAXB; j++) begin
      rank[j]     = RANK_W'($countones(run_start & ~({MAXB{1'b1}} << j)));
      run_word[j] = '0;
      alive       = 1'b1;
      for (int m = 0; m < WORD_BYTES; m++) begin
        alive = alive && cap_pad[j+m];
        if (alive) begin
          run_word[j][8*m +: 8] = nb_pad[j+m];
        end
      end
    end
    for (int r = 0; r < RUN_SLOTS; r++) begin
      vals[r] = '0;
      for (int j = 0; j < MAXB; j++) begin
        if (run_start[j] && (rank[j] == RANK_W'(r))) begin
          vals[r] = vals[r] | run_word[j];
        end
      end
    end
    runs_raw = RANK_W'($countones(run_start));
    runs_cnt = (runs_raw > RANK_W'(RUN_SLOTS)) ? CNT_W'(RUN_SLOTS) : CNT_W'(runs_raw);
  end

  // candidate and match decision
  logic                    cand, match_ok;
  logic [OFFSET_BITS-1:0]  start_off;
  logic [OFFSET_BITS+31:0] off_wide;

  always_comb begin
    if (len_eff == '0) begin
      cand = (byte_cnt_q == '0);
    end else begin
      cand = (byte_cnt_q >= OFFSET_BITS'(len_m1)) && (phase_q == mod_small(len_m1, step_eff));
    end
  end

  assign start_off = (len_eff == '0) ? '0 : byte_cnt_q - OFFSET_BITS'(len_m1);
  assign off_wide  = {32'd0, start_off};
  assign match_ok  = !match_done_q && cand && (miss == '0);

  // report buffer
  logic     rep_load, rep_busy, rep_last;
  rep_hdr_t rep_hdr;
  logic [RUN_SLOTS-1:0][31:0] rep_vals;

  assign in_ready_o = !rep_busy || match_done_q || (out_ready_i && rep_last);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rep_load   = in_fire && !match_done_q && (match_ok || last_byte_i);

  always_comb begin
    rep_hdr.found        = match_ok;
    rep_hdr.match_offset = match_ok ? off_wide[31:0] : '0;
    rep_hdr.arg_count    = match_ok ? runs_cnt : '0;
    rep_vals             = match_ok ? vals : '0;
  end

  wbss_report #(
    .RUN_SLOTS (RUN_SLOTS)
  ) u_report (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (rep_load),
    .hdr_i          (rep_hdr),
    .vals_i         (rep_vals),
    .busy_o         (rep_busy),
    .last_o         (rep_last),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o),
    .arg_count_o    (arg_count_o),
    .arg_index_o    (arg_index_o),
    .arg_value_o    (arg_value_o),
    .last_result_o  (last_result_o)
  );

  // advance region state
  always_comb begin
    byte_cnt_d   = byte_cnt_q;
    phase_d      = phase_q;
    match_done_d = match_done_q;
    if (in_fire) begin
      if (last_byte_i) begin
        byte_cnt_d   = '0;
        phase_d      = '0;
        match_done_d = 1'b0;
      end else begin
        if (byte_cnt_q != '1) begin
          byte_cnt_d = byte_cnt_q + OFFSET_BITS'(1);
        end
        phase_d      = ({1'b0, phase_q} + 5'd1 >= step_eff) ? '0 : phase_q + 4'd1;
        match_done_d = match_done_q || match_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      phase_q      <= '0;
      match_done_q <= 1'b0;
    end else begin
      byte_cnt_q   <= byte_cnt_d;
      phase_q      <= phase_d;
      match_done_q <= match_done_d;
    end
  end

  `WBSS_ASSERT_IMP(a_no_report_overwrite, rep_load && rep_busy, out_ready_i && rep_last, "report overwritten")
  `WBSS_ASSERT_NXT(a_region_cleared, in_fire && last_byte_i, (byte_cnt_q == '0) && (phase_q == '0) && !match_done_q, "region state not cleared")
  `WBSS_ASSERT_IMP(a_not_found_shape, out_valid_o && !found_o, last_result_o && (arg_count_o == '0) && (arg_value_o == '0), "malformed not-found item")

endmodule

`default_nettype wire

FILE: test/wbss_scan_checker.sv
// Scoreboard for the wildcard byte signature scan core: watches the config port and both
// item channels, predicts every result item and compares it field by field.
// Depends on wbss_pkg for register indexes and field widths.
module wbss_scan_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wbss_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  wire logic [wbss_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           last_byte_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  input  wire logic                           found_i,
  input  wire logic [31:0]                    match_offset_i,
  input  wire logic [wbss_pkg::CNT_W-1:0]     arg_count_i,
  input  wire logic [wbss_pkg::IDX_OUT_W-1:0] arg_index_i,
  input  wire logic [31:0]                    arg_value_i,
  input  wire logic                           last_result_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import wbss_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [31:0]          offset;
    logic [CNT_W-1:0]     count;
    logic [IDX_OUT_W-1:0] index;
    logic [31:0]          value;
    logic                 last;
  } scan_result_t;

  scan_result_t awaited_results[$];

  logic [127:0] pattern;
  logic [15:0]  cmp_mask;
  logic [15:0]  cap_mask;
  logic [4:0]   tlen;
  logic [4:0]   step;

  logic [7:0]   window [POS_LIMIT];
  logic [31:0]  byte_count;
  logic [3:0]   phase;
  logic         match_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic clear_region();
    for (int k = 0; k < POS_LIMIT; k++) window[k] = '0;
    byte_count = '0;
    phase      = '0;
    match_seen = 1'b0;
  endtask

  task automatic expect_result(input logic fnd, input logic [31:0] off,
                               input logic [CNT_W-1:0] cnt, input logic [IDX_OUT_W-1:0] idx,
                               input logic [31:0] val, input logic lst);
    scan_result_t r;
    r.found  = fnd;
    r.offset = off;
    r.count  = cnt;
    r.index  = idx;
    r.value  = val;
    r.last   = lst;
    awaited_results = {awaited_results, r};
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic tail);
    int unsigned len;
    int unsigned stp;
    int unsigned runs;
    int unsigned run_len;
    int unsigned cnt;
    logic [31:0] start;
    logic [31:0] vals [DEF_MAX_CAPTURES];
    logic [7:0]  v;
    bit          cand;
    bit          ok;
    len     = (tlen > 5'd16) ? 16 : tlen;
    stp     = (step == 5'd0) ? 1 : ((step > 5'd16) ? 16 : step);
    runs    = 0;
    run_len = 0;
    start   = '0;
    cand    = 1'b0;
    ok      = 1'b1;
    for (int k = 0; k < DEF_MAX_CAPTURES; k++) vals[k] = '0;
    if (!match_seen) begin
      for (int k = 0; k < POS_LIMIT - 1; k++) window[k] = window[k+1];
      window[POS_LIMIT-1] = b;
      if (len == 0) begin
        cand = (byte_count == 0);
      end else if (byte_count >= len - 1 && phase == (len - 1) % stp) begin
        cand  = 1'b1;
        start = byte_count - (len - 1);
      end
      if (cand) begin
        for (int k = 0; k < len && ok; k++) begin
          v = window[POS_LIMIT - len + k];
          if (cap_mask[k]) begin
            if (run_len == 0) begin
              if (runs < DEF_MAX_CAPTURES) vals[runs] = '0;
              runs++;
            end
            if (run_len < WORD_BYTES && runs <= DEF_MAX_CAPTURES)
              vals[runs-1] |= 32'(v) << (8 * run_len);
            run_len++;
          end else begin
            run_len = 0;
            if (cmp_mask[k] && v != pattern[8*k +: 8]) ok = 1'b0;
          end
        end
        if (ok) begin
          cnt = (runs > DEF_MAX_CAPTURES) ? DEF_MAX_CAPTURES : runs;
          if (cnt == 0) begin
            expect_result(1'b1, start, '0, '0, '0, 1'b1);
          end else begin
            for (int k = 0; k < cnt; k++)
              expect_result(1'b1, start, CNT_W'(cnt), IDX_OUT_W'(k), vals[k], k + 1 == cnt);
          end
          match_seen = 1'b1;
        end
      end
    end
    if (tail) begin
      if (!match_seen) expect_result(1'b0, '0, '0, '0, '0, 1'b1);
      clear_region();
    end else begin
      if (byte_count != '1) byte_count++;
      phase = (32'(phase) + 1 >= stp) ? 4'd0 : phase + 4'd1;
    end
  endtask

  task automatic check_result();
    scan_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with none awaited", arg_value_i, '0);
      return;
    end
    want = awaited_results.pop_front();
    if (found_i !== want.found) report_mismatch("found", 32'(found_i), 32'(want.found));
    if (match_offset_i !== want.offset)
      report_mismatch("match_offset", match_offset_i, want.offset);
    if (arg_count_i !== want.count)
      report_mismatch("arg_count", 32'(arg_count_i), 32'(want.count));
    if (arg_index_i !== want.index)
      report_mismatch("arg_index", 32'(arg_index_i), 32'(want.index));
    if (arg_value_i !== want.value) report_mismatch("arg_value", arg_value_i, want.value);
    if (last_result_i !== want.last)
      report_mismatch("last_result", 32'(last_result_i), 32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern  = '0;
      cmp_mask = '0;
      cap_mask = '0;
      tlen     = '0;
      step     = STEP_RESET;
      clear_region();
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_PAT_LO:   pattern[63:0]   = cfg_wdata_i;
          REG_PAT_HI:   pattern[127:64] = cfg_wdata_i;
          REG_CMP_MASK: cmp_mask        = cfg_wdata_i[15:0];
          REG_CAP_MASK: cap_mask        = cfg_wdata_i[15:0];
          REG_TLEN:     tlen            = cfg_wdata_i[4:0];
          REG_STEP:     step            = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) scan_byte(data_byte_i, last_byte_i);
      pending_o = awaited_results.size();
    end
  end

endmodule

FILE: test/tb_wildcard_byte_signature_scan_core.sv
// Testbench top for the wildcard byte signature scan core: clock, reset, template setup,
// byte regions with random idling and back-pressure, and the final verdict.
// Depends on wbss_pkg, the core and wbss_scan_checker.
module tb_wildcard_byte_signature_scan_core;
  import wbss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {REGION_NOISE, REGION_CLEAN, REGION_BROKEN} region_kind_e;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr  = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic [7:0]          data_byte = '0;
  logic                last_byte = 1'b0;
  logic                out_ready = 1'b0;

  wire logic                 in_ready;
  wire logic                 out_valid;
  wire logic                 found;
  wire logic [31:0]          match_offset;
  wire logic [CNT_W-1:0]     arg_count;
  wire logic [IDX_OUT_W-1:0] arg_index;
  wire logic [31:0]          arg_value;
  wire logic                 last_result;

  int fail_count;
  int pending;
  int cycles     = 0;
  int items_sent = 0;
  bit calm       = 1'b0;
  int hold_asks  = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  logic [127:0] cur_pat  = '0;
  logic [15:0]  cur_cmp  = '0;
  logic [15:0]  cur_cap  = '0;
  logic [4:0]   cur_tlen = '0;
  logic [4:0]   cur_step = STEP_RESET;

  wildcard_byte_signature_scan_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .found_o       (found),
    .match_offset_o(match_offset),
    .arg_count_o   (arg_count),
    .arg_index_o   (arg_index),
    .arg_value_o   (arg_value),
    .last_result_o (last_result)
  );

  wbss_scan_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .found_i       (found),
    .match_offset_i(match_offset),
    .arg_count_i   (arg_count),
    .arg_index_i   (arg_index),
    .arg_value_i   (arg_value),
    .last_result_i (last_result),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[wildcard_byte_signature_scan_core] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 30);
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
  endtask

  task automatic load_template(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] cmp, input logic [15:0] cap,
                               input logic [4:0] tl, input logic [4:0] st);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_CMP_MASK, 64'(cmp));
    write_reg(REG_CAP_MASK, 64'(cap));
    write_reg(REG_TLEN, 64'(tl));
    write_reg(REG_STEP, 64'(st));
    cfg_we   <= 1'b0;
    cur_pat  = {hi, lo};
    cur_cmp  = cmp;
    cur_cap  = cap;
    cur_tlen = tl;
    cur_step = st;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic tail);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= tail;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic scan_region(input region_kind_e kind);
    int unsigned len;
    int unsigned stp;
    int unsigned start;
    int unsigned total;
    int unsigned k;
    logic [7:0]  region [64];
    len   = (cur_tlen > 5'd16) ? 16 : cur_tlen;
    stp   = (cur_step == 5'd0) ? 1 : ((cur_step > 5'd16) ? 16 : cur_step);
    start = 0;
    if (kind == REGION_NOISE) begin
      total = $urandom_range(1, 20);
    end else begin
      start = stp * $urandom_range(0, 2);
      total = start + len + $urandom_range(0, 2);
      if (total == 0) total = 1;
    end
    for (int i = 0; i < total; i++) region[i] = 8'($urandom);
    if (kind != REGION_NOISE) begin
      for (int j = 0; j < len; j++)
        if (cur_cmp[j] && !cur_cap[j]) region[start + j] = cur_pat[8*j +: 8];
      if (kind == REGION_BROKEN && len > 0) begin
        k = $urandom_range(0, len - 1);
        region[start + k] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < total; i++) push_byte(region[i], i == total - 1);
  endtask

  initial begin
    int phase_end;
    int r;
    region_kind_e kind;
    logic [4:0]  tl;
    logic [4:0]  st;
    logic [15:0] cap;
    logic [15:0] cmp;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty template at reset settings: hit on the first byte
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    wait_idle();

    // plain literal, no captures: hit on the last byte, then a region with no hit
    load_template(64'hEFBE_ADDE, 64'h0, 16'h000F, 16'h0000, 5'd4, 5'd4);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'hBE, 1'b0);
    push_byte(8'hEF, 1'b1);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b1);
    wait_idle();

    // oversized length and step, eight single-byte capture runs
    load_template(64'h8877_6655_4433_2211, 64'h0FED_CBA9_7654_3210,
                  16'hAAAA, 16'h5555, 5'd31, 5'd17);
    for (int k = 0; k < 16; k++)
      push_byte(k[0] ? cur_pat[8*k +: 8] : 8'($urandom), k == 15);
    wait_idle();

    // step shrinks mid-region: stale phase drops back to zero
    load_template(64'h5A, 64'h0, 16'h0001, 16'h0000, 5'd1, 5'd16);
    repeat (6) push_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(REG_STEP, 64'd3);
    cfg_we   <= 1'b0;
    cur_step = 5'd3;
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      calm <= (ph == 2);
      if (ph == 5) begin
        load_template({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 16'h0005,
                      5'd4, 5'd1);
        hold_asks <= hold_asks + 1;
        repeat (4) scan_region(REGION_CLEAN);
      end else begin
        case (ph)
          0:       st = 5'd1;
          1:       st = 5'd31;
          2:       st = 5'd0;
          3:       st = 5'd16;
          default: st = 5'($urandom_range(0, 31));
        endcase
        if (ph == 3)          tl = 5'd0;
        else if (ph == 1)     tl = 5'd31;
        else if (ph % 3 == 0) tl = 5'd16;
        else                  tl = 5'($urandom_range(1, 12));
        case (ph % 5)
          0:       cap = 16'h5555;
          1:       cap = 16'h00FC;
          2:       cap = 16'h0000;
          3:       cap = 16'hFFFF;
          default: cap = 16'($urandom);
        endcase
        cmp = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        load_template({$urandom, $urandom}, {$urandom, $urandom}, cmp, cap, tl, st);
        phase_end = items_sent + 16;
        while (items_sent < phase_end) begin
          r = $urandom_range(99);
          kind = (r < 65) ? REGION_CLEAN : ((r < 85) ? REGION_BROKEN : REGION_NOISE);
          scan_region(kind);
        end
      end
      wait_idle();
    end

    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[wildcard_byte_signature_scan_core] OK");
    end else begin
      $display("[wildcard_byte_signature_scan_core] ERROR");
    end
    $finish;
  end

endmodule
